@@ design/ptc_pkg.sv @@
// Package: types and helpers for the pressure and temperature compensation pipeline.
package ptc_pkg;

  localparam int unsigned NumStages = 45;
  localparam int unsigned DivBits = 32;

  typedef enum logic [1:0] {
    REG_TEMP_CALIB = 2'd0,
    REG_PRESS_LOW  = 2'd1,
    REG_PRESS_HIGH = 2'd2,
    REG_PRESS_P9   = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [19:0] adc_temperature;
    logic [19:0] adc_pressure;
  } ptc_in_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic signed [31:0] fine_temperature;
    logic [31:0]        pressure_comp;
    logic               pressure_valid;
  } ptc_out_t;

  // Arithmetic right shift of a 32-bit word.
  function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
    asr = 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] f;
    f = a * b;
    mul32 = f[31:0];
  endfunction

endpackage

@@ design/ptc_stream_if.sv @@
// Interface: valid/ready channel carrying one payload.
interface ptc_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/ptc_divider.sv @@
// Pipelined restoring divider, one quotient bit per stage.
module ptc_divider (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic [31:0] quotient
);
  import ptc_pkg::*;

  logic [31:0] rem [DivBits+1];
  logic [31:0] quo [DivBits+1];
  logic [31:0] dvs [DivBits+1];

  assign rem[0] = '0;
  assign quo[0] = dividend;
  assign dvs[0] = divisor;

  for (genvar i = 0; i < DivBits; i++) begin : g_step
    logic [32:0] shifted;
    logic [32:0] diff;
    logic [31:0] rem_next;
    logic [31:0] quo_next;
    always_comb begin
      shifted  = {rem[i], quo[i][31]};
      diff     = shifted - {1'b0, dvs[i]};
      rem_next = diff[32] ? shifted[31:0] : diff[31:0];
      quo_next = {quo[i][30:0], ~diff[32]};
    end
    logic [31:0] rem_q;
    logic [31:0] quo_q;
    logic [31:0] dvs_q;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q <= rem_next;
        quo_q <= quo_next;
        dvs_q <= dvs[i];
      end
    end
    assign rem[i+1] = rem_q;
    assign quo[i+1] = quo_q;
    assign dvs[i+1] = dvs_q;
  end

  assign quotient = quo[DivBits];
endmodule

@@ design/pressure_temperature_compensation.sv @@
// Top level: pipelined 32-bit integer temperature and pressure compensation.
// Pipeline depth: 45 register stages.
// Throughput: one request per cycle unless stalled; the 32-stage divider sets the depth.
// A stall freezes every stage; the output stage refills when taken.
// Synchronous reset clears valid bits and calibration registers to zero.
module pressure_temperature_compensation (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [63:0]           cfg_data,
  ptc_stream_if.sink            in_ch,
  ptc_stream_if.source          out_ch
);
  import ptc_pkg::*;

  logic [47:0] temp_calib;
  logic [63:0] press_low;
  logic [63:0] press_high;
  logic [15:0] press_p9;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calib <= '0;
      press_low  <= '0;
      press_high <= '0;
      press_p9   <= '0;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_TEMP_CALIB: temp_calib <= cfg_data[47:0];
        REG_PRESS_LOW:  press_low  <= cfg_data;
        REG_PRESS_HIGH: press_high <= cfg_data;
        REG_PRESS_P9:   press_p9   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = {16'd0, temp_calib[15:0]};
  assign t2 = sx16(temp_calib[31:16]);
  assign t3 = sx16(temp_calib[47:32]);
  assign p1 = {16'd0, press_low[15:0]};
  assign p2 = sx16(press_low[31:16]);
  assign p3 = sx16(press_low[47:32]);
  assign p4 = sx16(press_low[63:48]);
  assign p5 = sx16(press_high[15:0]);
  assign p6 = sx16(press_high[31:16]);
  assign p7 = sx16(press_high[47:32]);
  assign p8 = sx16(press_high[63:48]);
  assign p9 = sx16(press_p9);

  // Global stall: pipeline advances when the output slot is free or taken.
  logic [NumStages-1:0] vld;
  logic en;
  assign en = ~vld[NumStages-1] | out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NumStages-2:0], in_ch.valid};
    end
  end

  // Stage 1: capture, first products.
  logic [31:0] s1_at, s1_ap, s1_ma, s1_d;
  always_ff @(posedge clk) begin
    if (en) begin
      s1_at <= {12'd0, in_ch.data.adc_temperature};
      s1_ap <= {12'd0, in_ch.data.adc_pressure};
      s1_ma <= mul32(({15'd0, in_ch.data.adc_temperature[19:3]}) - (t1 << 1), t2);
      s1_d  <= ({16'd0, in_ch.data.adc_temperature[19:4]}) - t1;
    end
  end

  // Stage 2
  logic [31:0] s2_a, s2_dd, s2_ap;
  always_ff @(posedge clk) begin
    if (en) begin
      s2_a  <= asr(s1_ma, 5'd11);
      s2_dd <= mul32(s1_d, s1_d);
      s2_ap <= s1_ap;
    end
  end

  // Stage 3
  logic [31:0] s3_a, s3_m, s3_ap;
  always_ff @(posedge clk) begin
    if (en) begin
      s3_a  <= s2_a;
      s3_m  <= mul32(asr(s2_dd, 5'd12), t3);
      s3_ap <= s2_ap;
    end
  end

  // Stage 4: fine temperature.
  logic [31:0] s4_tf, s4_ap;
  always_ff @(posedge clk) begin
    if (en) begin
      s4_tf <= s3_a + asr(s3_m, 5'd14);
      s4_ap <= s3_ap;
    end
  end

  // Stage 5
  logic [31:0] s5_tf, s5_temp_m, s5_a, s5_ap;
  always_ff @(posedge clk) begin
    if (en) begin
      s5_tf     <= s4_tf;
      s5_temp_m <= mul32(s4_tf, 32'd5);
      s5_a      <= asr(s4_tf, 5'd1) - 32'd64000;
      s5_ap     <= s4_ap;
    end
  end

  // Stage 6
  logic [31:0] s6_tf, s6_temp, s6_a, s6_qq, s6_a5, s6_a2, s6_ap;
  always_ff @(posedge clk) begin
    if (en) begin
      s6_tf   <= s5_tf;
      s6_temp <= asr(s5_temp_m + 32'd128, 5'd8);
      s6_a    <= s5_a;
      s6_qq   <= mul32(asr(s5_a, 5'd2), asr(s5_a, 5'd2));
      s6_a5   <= mul32(s5_a, p5);
      s6_a2   <= mul32(p2, s5_a);
      s6_ap   <= s5_ap;
    end
  end

  // Stage 7
  logic [31:0] s7_tf, s7_temp, s7_b6, s7_a5, s7_p3, s7_a2, s7_ap;
  always_ff @(posedge clk) begin
    if (en) begin
      s7_tf   <= s6_tf;
      s7_temp <= s6_temp;
      s7_b6   <= mul32(asr(s6_qq, 5'd11), p6);
      s7_a5   <= s6_a5;
      s7_p3   <= mul32(p3, asr(s6_qq, 5'd13));
      s7_a2   <= s6_a2;
      s7_ap   <= s6_ap;
    end
  end

  // Stage 8
  logic [31:0] s8_tf, s8_temp, s8_b, s8_x, s8_ap;
  always_ff @(posedge clk) begin
    if (en) begin
      s8_tf   <= s7_tf;
      s8_temp <= s7_temp;
      s8_b    <= asr(s7_b6 + (s7_a5 << 1), 5'd2) + (p4 << 16);
      s8_x    <= asr(asr(s7_p3, 5'd3) + asr(s7_a2, 5'd1), 5'd18);
      s8_ap   <= s7_ap;
    end
  end

  // Stage 9
  logic [31:0] s9_tf, s9_temp, s9_b, s9_m, s9_ap;
  always_ff @(posedge clk) begin
    if (en) begin
      s9_tf   <= s8_tf;
      s9_temp <= s8_temp;
      s9_b    <= s8_b;
      s9_m    <= mul32(32'd32768 + s8_x, p1);
      s9_ap   <= s8_ap;
    end
  end

  // Stage 10: divisor and numerator.
  logic [31:0] s10_tf, s10_temp, s10_div, s10_num;
  always_ff @(posedge clk) begin
    if (en) begin
      s10_tf   <= s9_tf;
      s10_temp <= s9_temp;
      s10_div  <= asr(s9_m, 5'd15);
      s10_num  <= mul32((32'd1048576 - s9_ap) - asr(s9_b, 5'd12), 32'd3125);
    end
  end

  logic s10_hi;
  logic [31:0] dividend, quotient;
  assign s10_hi   = s10_num[31];
  assign dividend = s10_hi ? s10_num : (s10_num << 1);

  ptc_divider u_div (
    .clk      (clk),
    .en       (en),
    .dividend (dividend),
    .divisor  (s10_div),
    .quotient (quotient)
  );

  // Side data delayed along the divider.
  logic [31:0] dl_tf [DivBits];
  logic [31:0] dl_temp [DivBits];
  logic [DivBits-1:0] dl_hi, dl_zero;
  always_ff @(posedge clk) begin
    if (en) begin
      dl_tf[0]   <= s10_tf;
      dl_temp[0] <= s10_temp;
      dl_hi[0]   <= s10_hi;
      dl_zero[0] <= (s10_div == '0);
      for (int i = 1; i < DivBits; i++) begin
        dl_tf[i]   <= dl_tf[i-1];
        dl_temp[i] <= dl_temp[i-1];
      end
      dl_hi[DivBits-1:1]   <= dl_hi[DivBits-2:0];
      dl_zero[DivBits-1:1] <= dl_zero[DivBits-2:0];
    end
  end

  // Post stage A: quotient fixup and r term.
  logic [31:0] pa_p, pa_rr, pa_b8, pa_tf, pa_temp;
  logic pa_zero;
  logic [31:0] q_fix;
  assign q_fix = dl_hi[DivBits-1] ? (quotient << 1) : quotient;
  always_ff @(posedge clk) begin
    if (en) begin
      pa_p    <= q_fix;
      pa_rr   <= mul32({3'd0, q_fix[31:3]}, {3'd0, q_fix[31:3]});
      pa_b8   <= mul32({2'd0, q_fix[31:2]}, p8);
      pa_tf   <= dl_tf[DivBits-1];
      pa_temp <= dl_temp[DivBits-1];
      pa_zero <= dl_zero[DivBits-1];
    end
  end

  // Post stage B
  logic [31:0] pb_p, pb_a9, pb_b, pb_tf, pb_temp;
  logic pb_zero;
  always_ff @(posedge clk) begin
    if (en) begin
      pb_p    <= pa_p;
      pb_a9   <= mul32(p9, pa_rr >> 13);
      pb_b    <= asr(pa_b8, 5'd13);
      pb_tf   <= pa_tf;
      pb_temp <= pa_temp;
      pb_zero <= pa_zero;
    end
  end

  // Output register.
  ptc_out_t res;
  always_ff @(posedge clk) begin
    if (en) begin
      res.temperature_centi <= pb_temp;
      res.fine_temperature  <= pb_tf;
      res.pressure_comp     <= pb_zero ? '0
                             : pb_p + asr(asr(pb_a9, 5'd12) + pb_b + p7, 5'd4);
      res.pressure_valid    <= ~pb_zero;
    end
  end

  assign out_ch.valid = vld[NumStages-1];
  assign out_ch.data  = res;
endmodule

@@ design/ptc_checker.sv @@
// Checker: port-level properties of the compensation block, bound to the top level.
module ptc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_pressure,
  input logic        out_pvalid
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_pvalid |-> out_pressure == 32'd0) else $error("bad zero pressure");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready) else $error("stall without result");
  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !out_valid) else $error("valid after reset");
endmodule

bind pressure_temperature_compensation ptc_checker u_ptc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_pressure (out_ch.data.pressure_comp),
  .out_pvalid   (out_ch.data.pressure_valid)
);
